// ===== sv/stc_pkg.sv =====
// Shared types, codes and constants for the synced time to calendar block.
// Used by stc_ctrl, stc_dp, synced_time_to_calendar_unit and the verif files; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

	// Request and result payloads
	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_ms;
		logic [31:0] ntp_seconds;
	} in_item_t;

	typedef struct packed {
		logic        time_valid;
		logic        refresh_due;
		logic [31:0] unix_seconds;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} out_item_t;

	// Action codes
	localparam logic [1:0] ACT_QUERY = 2'd0;
	localparam logic [1:0] ACT_SYNC  = 2'd1;
	localparam logic [1:0] ACT_FAIL  = 2'd2;

	// Register indexes
	localparam logic [1:0] CFG_TZ_OFFSET = 2'd0;
	localparam logic [1:0] CFG_REFRESH   = 2'd1;
	localparam logic [1:0] CFG_RETRY     = 2'd2;

	// Register reset values
	localparam logic [10:0] TZ_RESET      = 11'd0;
	localparam logic [31:0] REFRESH_RESET = 32'd18000000;
	localparam logic [31:0] RETRY_RESET   = 32'd5000;

	// Time constants
	localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
	localparam logic [31:0] ROUND_MS        = 32'd500;

	// Reciprocals for exact 32-bit division: ceil(2^(32+s) / d), s = 6, 5, 4
	localparam logic [31:0] RECIP_1000 = 32'h10624DD3;
	localparam logic [31:0] RECIP_60   = 32'h88888889;
	localparam logic [31:0] RECIP_24   = 32'hAAAAAAAB;

	// Epoch year and its residues mod 4, 100 and 400
	localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
	localparam logic [1:0]  EPOCH_MOD4     = 2'd2;
	localparam logic [6:0]  EPOCH_MOD100   = 7'd70;
	localparam logic [8:0]  EPOCH_MOD400   = 9'd370;
	localparam logic [6:0]  LAST_MOD100    = 7'd99;
	localparam logic [8:0]  LAST_MOD400    = 9'd399;
	localparam logic [8:0]  DAYS_LEAP      = 9'd366;
	localparam logic [8:0]  DAYS_COMMON    = 9'd365;
	localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

	// Divisor select for the shared constant divider
	typedef enum logic [1:0] {
		DIV_BY_1000,
		DIV_BY_60,
		DIV_BY_24
	} div_sel_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_UPDATE,
		OP_DUE,
		OP_ROUND,
		OP_DIV_STEP,
		OP_SUM_BASE,
		OP_SUM_ZONE,
		OP_SPLIT_SEC,
		OP_SPLIT_MIN,
		OP_SPLIT_HOUR,
		OP_YEAR_STEP,
		OP_MONTH_STEP,
		OP_EMIT
	} dp_op_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DUE,
		ST_ROUND,
		ST_DIV_MS,
		ST_SUM_BASE,
		ST_SUM_ZONE,
		ST_DIV_SEC,
		ST_SPLIT_SEC,
		ST_DIV_MIN,
		ST_SPLIT_MIN,
		ST_DIV_HOUR,
		ST_SPLIT_HOUR,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} stc_state_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t div_sel;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic year_fits;
		logic month_fits;
		logic out_busy;
	} sts_t;

	function automatic logic [31:0] div_magic(input div_sel_t sel);
		logic [31:0] m;
		case (sel)
			DIV_BY_1000: m = RECIP_1000;
			DIV_BY_60:   m = RECIP_60;
			DIV_BY_24:   m = RECIP_24;
			default:     m = RECIP_1000;
		endcase
		return m;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd0:    n = 5'd31;
			4'd1:    n = leap ? 5'd29 : 5'd28;
			4'd2:    n = 5'd31;
			4'd3:    n = 5'd30;
			4'd4:    n = 5'd31;
			4'd5:    n = 5'd30;
			4'd6:    n = 5'd31;
			4'd7:    n = 5'd31;
			4'd8:    n = 5'd30;
			4'd9:    n = 5'd31;
			4'd10:   n = 5'd30;
			4'd11:   n = 5'd31;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== sv/stc_ctrl.sv =====
// Controller state machine for the synced time to calendar block.
// Depends on stc_pkg; drives the datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module stc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire stc_pkg::sts_t sts,
	output stc_pkg::cmd_t      cmd
);
	import stc_pkg::*;

	stc_state_t state_q;
	stc_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE:     state_d = ST_DUE;
			ST_DUE:        state_d = ST_ROUND;
			ST_ROUND:      state_d = ST_DIV_MS;
			ST_DIV_MS: begin
				if (sts.div_last) state_d = ST_SUM_BASE;
			end
			ST_SUM_BASE:   state_d = ST_SUM_ZONE;
			ST_SUM_ZONE:   state_d = ST_DIV_SEC;
			ST_DIV_SEC: begin
				if (sts.div_last) state_d = ST_SPLIT_SEC;
			end
			ST_SPLIT_SEC:  state_d = ST_DIV_MIN;
			ST_DIV_MIN: begin
				if (sts.div_last) state_d = ST_SPLIT_MIN;
			end
			ST_SPLIT_MIN:  state_d = ST_DIV_HOUR;
			ST_DIV_HOUR: begin
				if (sts.div_last) state_d = ST_SPLIT_HOUR;
			end
			ST_SPLIT_HOUR: state_d = ST_YEAR;
			ST_YEAR: begin
				if (sts.year_fits) state_d = ST_MONTH;
			end
			ST_MONTH: begin
				if (sts.month_fits) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	// Outputs: one datapath operation per state
	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		cmd.op      = OP_NONE;
		cmd.div_sel = DIV_BY_1000;
		case (state_q)
			ST_IDLE:       cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_UPDATE:     cmd.op = OP_UPDATE;
			ST_DUE:        cmd.op = OP_DUE;
			ST_ROUND:      cmd.op = OP_ROUND;
			ST_DIV_MS: begin
				cmd.op      = OP_DIV_STEP;
				cmd.div_sel = DIV_BY_1000;
			end
			ST_SUM_BASE:   cmd.op = OP_SUM_BASE;
			ST_SUM_ZONE:   cmd.op = OP_SUM_ZONE;
			ST_DIV_SEC: begin
				cmd.op      = OP_DIV_STEP;
				cmd.div_sel = DIV_BY_60;
			end
			ST_SPLIT_SEC:  cmd.op = OP_SPLIT_SEC;
			ST_DIV_MIN: begin
				cmd.op      = OP_DIV_STEP;
				cmd.div_sel = DIV_BY_60;
			end
			ST_SPLIT_MIN:  cmd.op = OP_SPLIT_MIN;
			ST_DIV_HOUR: begin
				cmd.op      = OP_DIV_STEP;
				cmd.div_sel = DIV_BY_24;
			end
			ST_SPLIT_HOUR: cmd.op = OP_SPLIT_HOUR;
			ST_YEAR:       cmd.op = OP_YEAR_STEP;
			ST_MONTH:      cmd.op = OP_MONTH_STEP;
			ST_DONE:       cmd.op = sts.out_busy ? OP_NONE : OP_EMIT;
			default:       cmd.op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/stc_dp.sv =====
// Datapath for the synced time to calendar block: registers, sync state,
// shared constant divider, year and month walk, result register. Depends on stc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stc_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stc_pkg::in_item_t in_data,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	input  wire stc_pkg::cmd_t     cmd,
	output stc_pkg::sts_t          sts,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output stc_pkg::out_item_t     out_data
);
	import stc_pkg::*;

	// Configuration and sync state
	logic [10:0] tz_q;
	logic [31:0] refresh_q;
	logic [31:0] retry_q;
	logic [31:0] last_q;
	logic [31:0] sync_q;
	logic [31:0] failed_q;
	logic        force_q;

	// Work registers
	in_item_t    item_q;
	logic        due_q;
	logic [31:0] elapsed_q;
	logic [31:0] num_q;
	logic [9:0]  rem_q;
	logic        cnt_q;
	logic [63:0] prod_q;
	logic [31:0] acc_q;
	logic [31:0] ts_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [15:0] days_q;
	logic [11:0] year_q;
	logic [1:0]  mod4_q;
	logic [6:0]  mod100_q;
	logic [8:0]  mod400_q;
	logic [3:0]  mon_q;
	logic [8:0]  start_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic        emit;
	logic        valid_time;
	logic [31:0] since_sync;
	logic [31:0] since_fail;
	logic [31:0] magic;
	logic [31:0] quot;
	logic [31:0] quot_d;
	logic [31:0] rem_full;
	logic [31:0] tz_ext;
	logic [31:0] tz_sec;
	logic [31:0] ts_next;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  dim;
	logic [9:0]  month_end;
	logic [8:0]  day_sum;

	assign emit       = (cmd.op == OP_EMIT);
	assign valid_time = (last_q != 32'd0);
	assign since_sync = item_q.now_ms - sync_q;
	assign since_fail = item_q.now_ms - failed_q;

	// Divider: multiply by the reciprocal, then take quotient and remainder
	assign magic = div_magic(cmd.div_sel);

	always_comb begin
		case (cmd.div_sel)
			DIV_BY_1000: begin
				quot   = {6'd0, prod_q[63:38]};
				quot_d = (quot << 10) - (quot << 4) - (quot << 3);
			end
			DIV_BY_60: begin
				quot   = {5'd0, prod_q[63:37]};
				quot_d = (quot << 6) - (quot << 2);
			end
			DIV_BY_24: begin
				quot   = {4'd0, prod_q[63:36]};
				quot_d = (quot << 4) + (quot << 3);
			end
			default: begin
				quot   = {6'd0, prod_q[63:38]};
				quot_d = (quot << 10) - (quot << 4) - (quot << 3);
			end
		endcase
	end

	assign rem_full = num_q - quot_d;

	// Timezone minutes to seconds: x*60 = x*64 - x*4
	assign tz_ext  = {{21{tz_q[10]}}, tz_q};
	assign tz_sec  = (tz_ext << 6) - (tz_ext << 2);
	assign ts_next = valid_time ? (acc_q + tz_sec) : 32'd0;

	// Leap year from tracked residues
	assign leap      = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign ylen      = leap ? DAYS_LEAP : DAYS_COMMON;
	assign dim       = month_len(mon_q, leap);
	assign month_end = {1'b0, start_q} + {5'd0, dim};
	assign day_sum   = days_q[8:0] - start_q + 9'd1;

	assign sts.div_last   = cnt_q;
	assign sts.year_fits  = (days_q < {7'd0, ylen});
	assign sts.month_fits = (mon_q >= LAST_MONTH_IDX) || ({6'd0, month_end} > days_q);
	assign sts.out_busy   = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration, sync state and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q        <= TZ_RESET;
			refresh_q   <= REFRESH_RESET;
			retry_q     <= RETRY_RESET;
			last_q      <= 32'd0;
			sync_q      <= 32'd0;
			failed_q    <= 32'd0;
			force_q     <= 1'b1;
			cnt_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// take register writes
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TZ_OFFSET: tz_q      <= cfg_data[10:0];
					CFG_REFRESH:   refresh_q <= cfg_data;
					CFG_RETRY:     retry_q   <= cfg_data;
					default:       ;
				endcase
			end
			// apply the request's action
			if (cmd.op == OP_UPDATE) begin
				if (item_q.action == ACT_SYNC) begin
					last_q   <= item_q.ntp_seconds - NTP_UNIX_OFFSET;
					sync_q   <= item_q.now_ms;
					failed_q <= 32'd0;
					force_q  <= 1'b0;
				end else if (item_q.action == ACT_FAIL) begin
					failed_q <= item_q.now_ms;
				end
			end
			// alternate multiply and split cycles, restart before each division
			case (cmd.op)
				OP_DIV_STEP:   cnt_q <= !cnt_q;
				OP_ROUND,
				OP_SUM_ZONE,
				OP_SPLIT_SEC,
				OP_SPLIT_MIN:  cnt_q <= 1'b0;
				default:       cnt_q <= cnt_q;
			endcase
			// hold the result until taken
			out_valid_q <= emit || (out_valid_q && out_stall);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: item_q <= in_data;
			OP_DUE: begin
				due_q     <= (force_q || (since_sync > refresh_q)) &&
				             ((failed_q == 32'd0) || (since_fail > retry_q));
				elapsed_q <= since_sync;
			end
			OP_ROUND: begin
				num_q <= elapsed_q + ROUND_MS;
				rem_q <= 10'd0;
			end
			OP_DIV_STEP: begin
				// cnt_q low forms the product, cnt_q high splits it
				if (!cnt_q) begin
					prod_q <= {32'd0, num_q} * {32'd0, magic};
				end else begin
					num_q <= quot;
					rem_q <= rem_full[9:0];
				end
			end
			OP_SUM_BASE: acc_q <= num_q + last_q;
			OP_SUM_ZONE: begin
				ts_q  <= ts_next;
				num_q <= ts_next;
				rem_q <= 10'd0;
			end
			OP_SPLIT_SEC: begin
				sec_q <= rem_q[5:0];
				rem_q <= 10'd0;
			end
			OP_SPLIT_MIN: begin
				min_q <= rem_q[5:0];
				rem_q <= 10'd0;
			end
			OP_SPLIT_HOUR: begin
				hour_q   <= rem_q[4:0];
				days_q   <= num_q[15:0];
				year_q   <= EPOCH_YEAR;
				mod4_q   <= EPOCH_MOD4;
				mod100_q <= EPOCH_MOD100;
				mod400_q <= EPOCH_MOD400;
				mon_q    <= 4'd0;
				start_q  <= 9'd0;
			end
			OP_YEAR_STEP: begin
				// drop one whole year while the days are still at least its length
				if (!sts.year_fits) begin
					days_q   <= days_q - {7'd0, ylen};
					year_q   <= year_q + 12'd1;
					mod4_q   <= mod4_q + 2'd1;
					mod100_q <= (mod100_q == LAST_MOD100) ? 7'd0 : mod100_q + 7'd1;
					mod400_q <= (mod400_q == LAST_MOD400) ? 9'd0 : mod400_q + 9'd1;
				end
			end
			OP_MONTH_STEP: begin
				// advance past whole months before the day of year
				if (!sts.month_fits) begin
					start_q <= month_end[8:0];
					mon_q   <= mon_q + 4'd1;
				end
			end
			OP_EMIT: begin
				out_q.time_valid   <= valid_time;
				out_q.refresh_due  <= due_q;
				out_q.unix_seconds <= ts_q;
				out_q.year         <= year_q;
				out_q.month        <= mon_q + 4'd1;
				out_q.day          <= day_sum[4:0];
				out_q.hour         <= hour_q;
				out_q.minute       <= min_q;
				out_q.second       <= sec_q;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/synced_time_to_calendar_unit.sv =====
// Top level of the synced time to calendar block: controller plus datapath.
// Depends on stc_pkg, stc_ctrl and stc_dp.
//
// Channel  | Signals                           | Handshake
// ---------+-----------------------------------+------------------------------
// request  | in_valid, in_stall, in_data       | accepted on valid && !stall
// result   | out_valid, out_stall, out_data    | taken on valid && !stall
// config   | cfg_valid, cfg_ready, cfg_index,  | written on valid && ready,
//          | cfg_data                          | ready is always high
//
// One request is processed at a time: load, update, refresh check and round,
// four constant divisions by reciprocal multiply, sums and splits, then a walk
// over the years from 1970 and over the months, and emit; the year walk takes
// the longest. A finished result sits in an output register, so the next
// request is accepted while it waits. Reset restores the register reset values
// and clears the sync state.
`timescale 1ns / 1ps
`default_nettype none

module synced_time_to_calendar_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire stc_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output stc_pkg::out_item_t     out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);
	import stc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	stc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	stc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== verif/stc_calendar_checker.sv =====
// Checker for the synced time to calendar unit: watches the request, result and
// register channels, predicts each calendar result and compares it field by field.
// Depends on stc_pkg for payload types, codes and reset values.
`timescale 1ns / 1ps

module stc_calendar_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_stall,
	input  stc_pkg::in_item_t  in_data,
	input  wire logic          out_valid,
	input  wire logic          out_stall,
	input  stc_pkg::out_item_t out_data,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	output int                 mismatches,
	output int                 compared,
	output int                 outstanding
);

	import stc_pkg::*;

	localparam int unsigned SEC_PER_DAY = 86400;
	localparam int unsigned MS_PER_SEC  = 1000;
	localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// Register copies
	logic [10:0] zone_min;
	logic [31:0] refresh_ms;
	logic [31:0] retry_ms;

	// Sync state copies
	logic [31:0] sync_unix;
	logic [31:0] sync_stamp_ms;
	logic [31:0] failed_stamp_ms;
	logic        refresh_forced;

	// Calendar results still owed by the block, oldest first
	out_item_t calendar_queue [$];

	function automatic bit leap(input int unsigned y);
		return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
	endfunction

	function automatic int unsigned month_span(input int unsigned m, input int unsigned y);
		return (m == 1 && leap(y)) ? 29 : MONTH_LEN[m];
	endfunction

	// Break local seconds into a calendar date by walking years, then months
	function automatic out_item_t split_calendar(input logic [31:0] ts);
		out_item_t   c;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		int unsigned start;
		c = '0;
		c.unix_seconds = ts;
		c.second = 6'(ts % 60);
		c.minute = 6'((ts / 60) % 60);
		c.hour   = 5'((ts / 3600) % 24);
		days = ts / SEC_PER_DAY;
		yr = EPOCH_YEAR;
		while (days >= (leap(yr) ? 366 : 365)) begin
			days -= leap(yr) ? 366 : 365;
			yr++;
		end
		mon = 0;
		start = 0;
		while (mon < 11 && start + month_span(mon, yr) <= days) begin
			start += month_span(mon, yr);
			mon++;
		end
		c.year  = 12'(yr);
		c.month = 4'(mon + 1);
		c.day   = 5'(days - start + 1);
		return c;
	endfunction

	// Update the sync state for one request and work out its result
	task automatic apply_request(input in_item_t r, output out_item_t res);
		logic [31:0]        since_sync;
		logic [31:0]        since_fail;
		logic [31:0]        rounded;
		logic signed [31:0] zone;
		logic [31:0]        zone_sec;
		logic [31:0]        local_ts;
		bit                 due;
		case (r.action)
			ACT_SYNC: begin
				sync_unix       = r.ntp_seconds - NTP_UNIX_OFFSET;
				sync_stamp_ms   = r.now_ms;
				failed_stamp_ms = '0;
				refresh_forced  = 1'b0;
			end
			ACT_FAIL: begin
				failed_stamp_ms = r.now_ms;
			end
			default: begin
			end
		endcase

		since_sync = r.now_ms - sync_stamp_ms;
		since_fail = r.now_ms - failed_stamp_ms;
		due = (refresh_forced || since_sync > refresh_ms) &&
			(failed_stamp_ms == 0 || since_fail > retry_ms);

		// Extrapolate: rounded elapsed seconds, zone shift, all modulo 2^32
		if (sync_unix == 0) begin
			local_ts = '0;
		end else begin
			rounded  = since_sync + ROUND_MS;
			zone     = $signed(zone_min);
			zone_sec = 32'(zone * 60);
			local_ts = rounded / MS_PER_SEC + zone_sec + sync_unix;
		end

		res = split_calendar(local_ts);
		res.time_valid  = (sync_unix != 0);
		res.refresh_due = due;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		out_item_t predicted;
		out_item_t want;
		string     diffs;
		if (!arst_n) begin
			zone_min        = TZ_RESET;
			refresh_ms      = REFRESH_RESET;
			retry_ms        = RETRY_RESET;
			sync_unix       = '0;
			sync_stamp_ms   = '0;
			failed_stamp_ms = '0;
			refresh_forced  = 1'b1;
			calendar_queue.delete();
			mismatches = 0;
			compared   = 0;
			outstanding <= 0;
		end else begin
			// Retire a result before taking a new request in the same cycle
			if (out_valid && !out_stall) begin
				if (calendar_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request pending: %p", $time, out_data);
				end else begin
					want = calendar_queue.pop_front();
					diffs = "";
					if (out_data.time_valid !== want.time_valid)
						diffs = {diffs, $sformatf(" time_valid %0d/%0d",
							want.time_valid, out_data.time_valid)};
					if (out_data.refresh_due !== want.refresh_due)
						diffs = {diffs, $sformatf(" refresh_due %0d/%0d",
							want.refresh_due, out_data.refresh_due)};
					if (out_data.unix_seconds !== want.unix_seconds)
						diffs = {diffs, $sformatf(" unix_seconds %0d/%0d",
							want.unix_seconds, out_data.unix_seconds)};
					if (out_data.year !== want.year)
						diffs = {diffs, $sformatf(" year %0d/%0d", want.year, out_data.year)};
					if (out_data.month !== want.month)
						diffs = {diffs, $sformatf(" month %0d/%0d", want.month, out_data.month)};
					if (out_data.day !== want.day)
						diffs = {diffs, $sformatf(" day %0d/%0d", want.day, out_data.day)};
					if (out_data.hour !== want.hour)
						diffs = {diffs, $sformatf(" hour %0d/%0d", want.hour, out_data.hour)};
					if (out_data.minute !== want.minute)
						diffs = {diffs, $sformatf(" minute %0d/%0d", want.minute, out_data.minute)};
					if (out_data.second !== want.second)
						diffs = {diffs, $sformatf(" second %0d/%0d", want.second, out_data.second)};
					compared++;
					if (diffs != "") begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result %0d wrong (expected/actual):%s",
								$time, compared, diffs);
					end
				end
			end

			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TZ_OFFSET: zone_min   = cfg_data[10:0];
					CFG_REFRESH:   refresh_ms = cfg_data;
					CFG_RETRY:     retry_ms   = cfg_data;
					default: begin
					end
				endcase
			end

			// Predict each accepted request
			if (in_valid && !in_stall) begin
				apply_request(in_data, predicted);
				calendar_queue.push_back(predicted);
			end

			outstanding <= calendar_queue.size();
		end
	end

endmodule

// ===== verif/synced_time_to_calendar_unit_test.sv =====
// Testbench top for synced_time_to_calendar_unit: drives requests, register
// writes and result stalls, and gives the verdict from the checker's count.
// Depends on stc_pkg, stc_calendar_checker and the unit itself.
`timescale 1ns / 1ps

module synced_time_to_calendar_unit_test;

	import stc_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 290;
	localparam int HOLD_CYCLES     = 3000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_CYCLES    = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	// Idling and hold-off controls
	int tx_idle_pct = 36;
	int rx_idle_pct = 70;
	bit hold_armed  = 1'b0;
	bit hold_done   = 1'b0;
	int hold_left   = 0;

	int          mismatches;
	int          compared;
	int          outstanding;
	int          requests = 0;
	logic [31:0] clock_ms = '0;

	always #5 clk = ~clk;

	// Give up on a hung run
	initial begin
		#25_000_000;
		$display("FAIL synced_time_to_calendar_unit");
		$finish;
	end

	synced_time_to_calendar_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	stc_calendar_checker calendar_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.compared    (compared),
		.outstanding (outstanding)
	);

	// Stall results at random; hold off once for a long stretch when armed
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Offer one request, idling first at random, and hold it until accepted
	task automatic offer(input logic [1:0] act, input logic [31:0] now, input logic [31:0] ntp);
		in_item_t req;
		req.action      = act;
		req.now_ms      = now;
		req.ntp_seconds = ntp;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests++;
	endtask

	// Write one register; the caller drops cfg_valid after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Wait until every predicted result has come back, then wait out the extra clocks
	task automatic wait_drained(input int extra);
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Mostly a steadily advancing counter with syncs, failures and queries;
	// some counter jumps, spare action codes and unrelated random requests
	task automatic random_burst(input int count);
		int          pick;
		logic [31:0] ntp;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				clock_ms = $urandom;
			else if (pick <= 6)
				clock_ms += $urandom_range(0, 3000);
			else if (pick <= 8)
				clock_ms += $urandom_range(0, 40000);

			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				case ($urandom_range(0, 9))
					0:       ntp = NTP_UNIX_OFFSET + $urandom_range(0, 100000);
					1:       ntp = NTP_UNIX_OFFSET - $urandom_range(1, 100000);
					default: ntp = $urandom;
				endcase
				offer(ACT_SYNC, clock_ms, ntp);
			end else if (pick < 20) begin
				offer(ACT_FAIL, ($urandom_range(0, 19) == 0) ? 32'd0 : clock_ms, $urandom);
			end else if (pick < 24) begin
				offer(ACT_SPARE, $urandom, $urandom);
			end else if (pick < 27) begin
				offer(ACT_QUERY, $urandom, $urandom);
			end else begin
				offer(ACT_QUERY, clock_ms, $urandom);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners under reset register values
		offer(ACT_QUERY, 32'd0, 32'd0);
		offer(ACT_FAIL, 32'd0, 32'hFFFF_FFFF);
		offer(ACT_FAIL, 32'd1000, 32'd0);
		offer(ACT_QUERY, 32'd6001, 32'd0);
		offer(ACT_QUERY, 32'd6000, 32'd0);
		// sync landing on the epoch leaves time invalid
		offer(ACT_SYNC, 32'd7000, NTP_UNIX_OFFSET);
		// leap day 2000, rounding just below and at half a second
		offer(ACT_SYNC, 32'd100, NTP_UNIX_OFFSET + 32'd951782400);
		offer(ACT_QUERY, 32'd599, 32'd0);
		offer(ACT_QUERY, 32'd600, 32'd0);
		offer(ACT_QUERY, 32'd100 + 32'd86399999, 32'd0);
		// elapsed all ones: rounding add wraps
		offer(ACT_QUERY, 32'd99, 32'd0);
		offer(ACT_QUERY, 32'd100 + 32'd18000001, 32'd0);
		offer(ACT_SPARE, 32'd200, 32'hFFFF_FFFF);
		// century year without a leap day
		offer(ACT_SYNC, 32'd0, NTP_UNIX_OFFSET + 32'd4107542399);
		offer(ACT_QUERY, 32'd1000, 32'd0);
		// last representable second
		offer(ACT_SYNC, 32'd5, NTP_UNIX_OFFSET - 32'd1);
		offer(ACT_QUERY, 32'd5, 32'd0);
		offer(ACT_SYNC, 32'hFFFF_FFFF, 32'd0);
		offer(ACT_SYNC, 32'd0, 32'hFFFF_FFFF);
		// year rollover
		offer(ACT_SYNC, 32'd1234, NTP_UNIX_OFFSET + 32'd946684799);
		offer(ACT_QUERY, 32'd2234, 32'd0);
		offer(ACT_SYNC, 32'd10, NTP_UNIX_OFFSET + 32'd1);
		offer(ACT_QUERY, 32'hFFFF_FFFF, 32'd0);
		in_valid <= 1'b0;

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained(SETTLE_CYCLES);

			// Reprogram registers while idle
			case (phase)
				0: begin
					write_reg(CFG_TZ_OFFSET, 32'(-720));
					write_reg(CFG_REFRESH, 32'd0);
					write_reg(CFG_RETRY, 32'd0);
				end
				1: begin
					write_reg(CFG_TZ_OFFSET, 32'd840);
					write_reg(CFG_REFRESH, 32'hFFFF_FFFF);
					write_reg(CFG_RETRY, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(CFG_TZ_OFFSET, $urandom);
					write_reg(CFG_REFRESH, 32'd1000);
					write_reg(CFG_RETRY, 32'd500);
					write_reg(CFG_SPARE, $urandom);
				end
				3: begin
					write_reg(CFG_TZ_OFFSET, 32'h3FF);
					write_reg(CFG_REFRESH, $urandom);
					write_reg(CFG_RETRY, $urandom_range(0, 20000));
				end
				4: begin
					write_reg(CFG_TZ_OFFSET, 32'h400);
					write_reg(CFG_REFRESH, REFRESH_RESET);
					write_reg(CFG_RETRY, RETRY_RESET);
				end
				default: begin
					write_reg(CFG_TZ_OFFSET, 32'($signed($urandom_range(0, 1560)) - 720));
					write_reg(CFG_REFRESH, 32'd30000);
					write_reg(CFG_RETRY, 32'd2000);
				end
			endcase
			cfg_valid <= 1'b0;

			// Receiver-heavy idling, then sender-heavy, then none
			tx_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 70 : 0;
			rx_idle_pct <= (phase < 2) ? 70 : (phase < 4) ? 36 : 0;
			if (phase == 4)
				hold_armed <= 1'b1;

			random_burst(ITEMS_PER_PHASE);
			in_valid <= 1'b0;
		end

		wait_drained(DRAIN_CYCLES);
		$display("Covered %0d requests: calendar corners, then %0d register settings.",
			requests, PHASES);
		$display("Compared %0d results, %0d mismatches.", compared, mismatches);
		if (mismatches == 0)
			$display("PASS synced_time_to_calendar_unit");
		else
			$display("FAIL synced_time_to_calendar_unit");
		$finish;
	end

endmodule

// ===== synced_time_to_calendar_unit.f =====
sv/stc_pkg.sv
sv/stc_ctrl.sv
sv/stc_dp.sv
sv/synced_time_to_calendar_unit.sv
verif/stc_calendar_checker.sv
verif/synced_time_to_calendar_unit_test.sv
